// File: rtl/core/tfmg_pkg.sv
package tfmg_pkg;

  localparam int unsigned PanelW   = 960;
  localparam int unsigned PanelH   = 544;
  localparam int unsigned CoordW   = 10;
  localparam int unsigned AmountW  = 11;
  localparam int unsigned CountW   = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned MaxEvents = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CoordW-1:0] XMax = CoordW'(PanelW - 1);
  localparam logic [CoordW-1:0] YMax = CoordW'(PanelH - 1);
  localparam logic [CoordW-1:0] ThresholdReset = CoordW'(12);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMouseEnabled   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScrollThreshold = 2'd1;

  typedef enum logic [2:0] {
    EvMove     = 3'd0,
    EvLPress   = 3'd1,
    EvLRelease = 3'd2,
    EvRPress   = 3'd3,
    EvRRelease = 3'd4,
    EvScroll   = 3'd5
  } event_kind_e;

  // one frame's worth of events, handed from front to back
  typedef struct packed {
    logic [1:0]                count;
    event_kind_e               kind0;
    event_kind_e               kind1;
    event_kind_e               kind2;
    logic [CoordW-1:0]         x;
    logic [CoordW-1:0]         y;
    logic signed [AmountW-1:0] amount;
  } run_t;

endpackage

// File: rtl/core/tfmg_if.sv
interface tfmg_frame_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [tfmg_pkg::CountW-1:0]   contacts_down;
  logic [tfmg_pkg::CoordW-1:0]   first_x;
  logic [tfmg_pkg::CoordW-1:0]   first_y;
  logic [tfmg_pkg::CoordW-1:0]   second_y;

  modport source (output valid, func, contacts_down, first_x, first_y, second_y,
                  input ready);
  modport sink   (input valid, func, contacts_down, first_x, first_y, second_y,
                  output ready);
endinterface

interface tfmg_event_if;
  logic                                 valid;
  logic                                 ready;
  logic [2:0]                           event_kind;
  logic [tfmg_pkg::CoordW-1:0]          pointer_x;
  logic [tfmg_pkg::CoordW-1:0]          pointer_y;
  logic signed [tfmg_pkg::AmountW-1:0]  scroll_amount;
  logic                                 last_of_run;

  modport source (output valid, event_kind, pointer_x, pointer_y, scroll_amount,
                  last_of_run, input ready);
  modport sink   (input valid, event_kind, pointer_x, pointer_y, scroll_amount,
                  last_of_run, output ready);
endinterface

interface tfmg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tfmg_pkg::CfgIdxW-1:0]  index;
  logic [tfmg_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/tfmg_front.sv
module tfmg_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  tfmg_frame_if.sink    frame_i,
  tfmg_cfg_if.sink      cfg_i,
  output logic          push_valid_o,
  output tfmg_pkg::run_t push_run_o,
  input  logic          push_ready_i
);
  import tfmg_pkg::*;

  logic              mouse_en_q;
  logic [CoordW-1:0] thresh_q;
  logic              left_held_q, left_held_d;
  logic              pair_active_q, pair_active_d;
  logic              pair_scroll_q, pair_scroll_d;
  logic              single_supp_q, single_supp_d;
  logic [CoordW-1:0] start_avg_q, start_avg_d;
  logic [CoordW-1:0] prev_avg_q, prev_avg_d;

  logic                accept;
  logic [CoordW-1:0]   x_c, y0_c, y1_c, avg, travel;
  logic [CoordW:0]     avg_sum;
  logic signed [AmountW-1:0] delta;
  logic                scroll_on;
  event_kind_e         kind_a [MaxEvents];
  logic [1:0]          n;

  assign cfg_i.ready   = 1'b1;
  assign frame_i.ready = push_ready_i;
  assign accept        = frame_i.valid & push_ready_i;

  assign x_c  = (frame_i.first_x  > XMax) ? XMax : frame_i.first_x;
  assign y0_c = (frame_i.first_y  > YMax) ? YMax : frame_i.first_y;
  assign y1_c = (frame_i.second_y > YMax) ? YMax : frame_i.second_y;

  assign avg_sum = {1'b0, y0_c} + {1'b0, y1_c};
  assign avg     = avg_sum[CoordW:1];
  assign delta   = $signed({1'b0, avg}) - $signed({1'b0, prev_avg_q});
  assign travel  = (avg >= start_avg_q) ? (avg - start_avg_q) : (start_avg_q - avg);
  assign scroll_on = pair_scroll_q | (travel > thresh_q);

  always_comb begin
    left_held_d   = left_held_q;
    pair_active_d = pair_active_q;
    pair_scroll_d = pair_scroll_q;
    single_supp_d = single_supp_q;
    start_avg_d   = start_avg_q;
    prev_avg_d    = prev_avg_q;
    n             = 2'd0;
    for (int i = 0; i < MaxEvents; i++) kind_a[i] = EvMove;

    if (frame_i.func || !mouse_en_q) begin
      if (left_held_q) begin
        kind_a[n] = EvLRelease;
        n = n + 2'd1;
      end
      left_held_d   = 1'b0;
      pair_active_d = 1'b0;
      pair_scroll_d = 1'b0;
      single_supp_d = 1'b0;
      start_avg_d   = '0;
      prev_avg_d    = '0;
    end else if (frame_i.contacts_down == '0) begin
      if (left_held_q) begin
        kind_a[n] = EvLRelease;
        n = n + 2'd1;
      end
      if (pair_active_q && !pair_scroll_q) begin
        kind_a[n] = EvRPress;
        n = n + 2'd1;
        kind_a[n] = EvRRelease;
        n = n + 2'd1;
      end
      left_held_d   = 1'b0;
      pair_active_d = 1'b0;
      pair_scroll_d = 1'b0;
      single_supp_d = 1'b0;
    end else begin
      kind_a[n] = EvMove;
      n = n + 2'd1;
      if (frame_i.contacts_down >= CountW'(2)) begin
        if (left_held_q) begin
          kind_a[n] = EvLRelease;
          n = n + 2'd1;
          left_held_d = 1'b0;
        end
        if (!pair_active_q) begin
          pair_active_d = 1'b1;
          pair_scroll_d = 1'b0;
          start_avg_d   = avg;
          prev_avg_d    = avg;
        end else begin
          pair_scroll_d = scroll_on;
          if (scroll_on && delta != '0) begin
            kind_a[n] = EvScroll;
            n = n + 2'd1;
          end
          prev_avg_d = avg;
        end
        single_supp_d = 1'b1;
      end else begin
        if (pair_active_q) begin
          if (!pair_scroll_q) begin
            kind_a[n] = EvRPress;
            n = n + 2'd1;
            kind_a[n] = EvRRelease;
            n = n + 2'd1;
          end
          pair_active_d = 1'b0;
          pair_scroll_d = 1'b0;
        end
        // no room for a press after a right click
        if (!single_supp_q && !left_held_q && n != 2'd3) begin
          kind_a[n] = EvLPress;
          n = n + 2'd1;
          left_held_d = 1'b1;
        end
      end
    end
  end

  assign push_valid_o       = accept & (n != 2'd0);
  assign push_run_o.count   = n;
  assign push_run_o.kind0   = kind_a[0];
  assign push_run_o.kind1   = kind_a[1];
  assign push_run_o.kind2   = kind_a[2];
  assign push_run_o.x       = x_c;
  assign push_run_o.y       = y0_c;
  assign push_run_o.amount  = delta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mouse_en_q    <= 1'b0;
      thresh_q      <= ThresholdReset;
      left_held_q   <= 1'b0;
      pair_active_q <= 1'b0;
      pair_scroll_q <= 1'b0;
      single_supp_q <= 1'b0;
      start_avg_q   <= '0;
      prev_avg_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CfgMouseEnabled:    mouse_en_q <= cfg_i.data[0];
          CfgScrollThreshold: thresh_q   <= cfg_i.data;
          default: ;
        endcase
      end
      if (accept) begin
        left_held_q   <= left_held_d;
        pair_active_q <= pair_active_d;
        pair_scroll_q <= pair_scroll_d;
        single_supp_q <= single_supp_d;
        start_avg_q   <= start_avg_d;
        prev_avg_q    <= prev_avg_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (frame_i.func || !mouse_en_q) |=> !left_held_q && !pair_active_q)
    else $error("release did not clear gesture flags");
  a_scroll_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_scroll_q |-> pair_active_q)
    else $error("scrolling without an active pair");
  a_pair_no_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_active_q |-> !left_held_q)
    else $error("left button held during a pair gesture");
`endif

endmodule

// File: rtl/core/tfmg_queue.sv
module tfmg_queue #(
  parameter int unsigned Depth = tfmg_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  tfmg_pkg::run_t push_run_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output tfmg_pkg::run_t pop_run_o,
  input  logic           pop_i
);
  import tfmg_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  run_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != Full;
  assign pop_valid_o  = cnt_q != '0;
  assign pop_run_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_i & pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_run_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_i |-> push_ready_o)
    else $error("word pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o)
    else $error("pop from an empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("queue count beyond depth");
`endif

endmodule

// File: rtl/core/tfmg_back.sv
module tfmg_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  tfmg_pkg::run_t pop_run_i,
  output logic           pop_o,
  tfmg_event_if.source   event_o
);
  import tfmg_pkg::*;

  run_t        cur_q;
  logic        cur_valid_q;
  logic [1:0]  pos_q;
  logic        out_valid_q;
  event_kind_e kind_q;
  logic [CoordW-1:0] px_q, py_q;
  logic signed [AmountW-1:0] amt_q;
  logic        last_q;

  logic        load_ok, emit, last, pop;
  event_kind_e kind_sel;

  assign load_ok = !out_valid_q || event_o.ready;
  assign emit    = cur_valid_q && load_ok;
  assign last    = pos_q == (cur_q.count - 2'd1);
  assign pop     = pop_valid_i && (!cur_valid_q || (emit && last));
  assign pop_o   = pop;

  always_comb begin
    case (pos_q)
      2'd0:    kind_sel = cur_q.kind0;
      2'd1:    kind_sel = cur_q.kind1;
      2'd2:    kind_sel = cur_q.kind2;
      default: kind_sel = cur_q.kind2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid_q <= 1'b1;
        pos_q       <= '0;
      end else if (emit) begin
        if (last) cur_valid_q <= 1'b0;
        pos_q <= pos_q + 2'd1;
      end
      if (emit)               out_valid_q <= 1'b1;
      else if (event_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) cur_q <= pop_run_i;
    if (emit) begin
      kind_q <= kind_sel;
      px_q   <= (kind_sel == EvMove)   ? cur_q.x : '0;
      py_q   <= (kind_sel == EvMove)   ? cur_q.y : '0;
      amt_q  <= (kind_sel == EvScroll) ? cur_q.amount : '0;
      last_q <= last;
    end
  end

  assign event_o.valid         = out_valid_q;
  assign event_o.event_kind    = kind_q;
  assign event_o.pointer_x     = px_q;
  assign event_o.pointer_y     = py_q;
  assign event_o.scroll_amount = amt_q;
  assign event_o.last_of_run   = last_q;

`ifndef SYNTHESIS
  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> cur_q.count != 2'd0 && pos_q < cur_q.count)
    else $error("serializer position outside its run");
  a_pointer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q != EvMove |-> px_q == '0 && py_q == '0)
    else $error("pointer fields set on a non-move word");
  a_amount_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q != EvScroll |-> amt_q == '0)
    else $error("scroll amount set on a non-scroll word");
`endif

endmodule

// File: rtl/core/two_finger_mouse_gesture.sv
// channel  dir  handshake     word
// frame_i  in   valid/ready   func, contacts_down, first_x, first_y, second_y
// event_o  out  valid/ready   event_kind, pointer_x, pointer_y, scroll_amount, last_of_run
// cfg_i    in   valid/ready   index, data (0 mouse_enabled, 1 scroll_trip)
//
// the front takes a frame every cycle while the run queue has room
// the back sends one event word a cycle while event_o is ready; a frame makes
// 0 to 3 events, and a frame that makes none is not pushed into the queue
// reset clears all gesture flags and averages, disables the mouse, threshold 12
// a stalled event_o holds its word; the queue lets frames keep arriving meanwhile until it is full
module two_finger_mouse_gesture #(
  parameter int unsigned QUEUE_DEPTH = tfmg_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tfmg_frame_if.sink   frame_i,
  tfmg_cfg_if.sink     cfg_i,
  tfmg_event_if.source event_o
);
  import tfmg_pkg::*;

  // front to queue
  logic push_valid, push_ready;
  run_t push_run;
  // queue to back
  logic pop_valid, pop;
  run_t pop_run;

  // front: config registers, gesture state, builds each frame's event run
  tfmg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (frame_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_run_o   (push_run),
    .push_ready_i (push_ready)
  );

  // short run queue decouples frame intake from event output
  tfmg_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_run_i   (push_run),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_run_o    (pop_run),
    .pop_i        (pop)
  );

  // back: serializes each run into event words behind an output register
  tfmg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_run_i   (pop_run),
    .pop_o       (pop),
    .event_o     (event_o)
  );

endmodule
